// ===== hw/rtl/scb_pkg.sv =====
// ----------------------------------------------------------------------------
// scb_pkg: colour bar pixel shared definitions
// Field widths, configuration register indexes and the bar colour tables.
// ----------------------------------------------------------------------------
package scb_pkg;

    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int COLOR_W    = 24;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [COLOR_W-1:0]    t_color;
    typedef logic [2:0]            t_bar;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_FRAME_HEIGHT = t_cfg_idx'(1);

    localparam t_cfg_data FRAME_WIDTH_RST  = t_cfg_data'(640);
    localparam t_cfg_data FRAME_HEIGHT_RST = t_cfg_data'(480);

    // Bar counts per band
    localparam int BOT_BARS = 8;
    localparam int SEV_BARS = 7;

    localparam t_color BOTTOM_BAND [BOT_BARS] = '{
        24'h001d42, 24'hebebeb, 24'h2c005c, 24'h101010,
        24'h070707, 24'h101010, 24'h181818, 24'h101010
    };

    localparam t_color MIDDLE_BAND [SEV_BARS] = '{
        24'h0f0fb4, 24'h101010, 24'hb410b4, 24'h101010,
        24'h0db4b4, 24'h101010, 24'hb4b4b4
    };

    localparam t_color TOP_BAND [SEV_BARS] = '{
        24'hb4b4b4, 24'hb4b40c, 24'h0db4b4, 24'h0db40c,
        24'hb410b4, 24'hb40f0e, 24'h0f0fb4
    };

endpackage

// ===== hw/rtl/scb_in_if.sv =====
// ----------------------------------------------------------------------------
// scb_in_if: pixel coordinate channel
// Valid/ready channel carrying one column/row request.
// ----------------------------------------------------------------------------
interface scb_in_if;
    import scb_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

// ===== hw/rtl/scb_out_if.sv =====
// ----------------------------------------------------------------------------
// scb_out_if: pixel colour channel
// Valid/ready channel carrying one colour result.
// ----------------------------------------------------------------------------
interface scb_out_if;
    import scb_pkg::*;

    logic   valid;
    logic   ready;
    t_color pixel_color;
    logic   outside_frame;

    modport source (output valid, output pixel_color, output outside_frame, input ready);
    modport sink   (input valid, input pixel_color, input outside_frame, output ready);
endinterface

// ===== hw/rtl/scb_cfg.sv =====
// ----------------------------------------------------------------------------
// scb_cfg: frame size registers and bar edge thresholds
// Holds width/height, clamps them, and keeps the scaled edge thresholds
// registered so the pixel path only compares.
// ----------------------------------------------------------------------------
module scb_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int WW         = 13,
    parameter int HW         = 13,
    parameter int CW         = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  scb_pkg::t_cfg_idx    i_cfg_idx,
    input  scb_pkg::t_cfg_data   i_cfg_data,
    output logic [WW-1:0]        o_w,
    output logic [HW-1:0]        o_h,
    output logic [CW-1:0]        o_bot_edge [scb_pkg::BOT_BARS-1],
    output logic [CW-1:0]        o_sev_edge [scb_pkg::SEV_BARS-1]
);
    import scb_pkg::*;

    t_cfg_data     r_frame_width;
    t_cfg_data     r_frame_height;
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [WW-1:0] n_w;
    logic [HW-1:0] n_h;
    logic [CW-1:0] r_bot_edge [BOT_BARS-1];
    logic [CW-1:0] r_sev_edge [SEV_BARS-1];
    logic [CW-1:0] n_bot_edge [BOT_BARS-1];
    logic [CW-1:0] n_sev_edge [SEV_BARS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp to the supported frame size
    always_comb begin
        if (int'(r_frame_width) > MAX_WIDTH) n_w = WW'(MAX_WIDTH);
        else                                 n_w = WW'(r_frame_width);
        if (int'(r_frame_height) > MAX_HEIGHT) n_h = HW'(MAX_HEIGHT);
        else                                   n_h = HW'(r_frame_height);
    end

    // x < (N + c) / d  is  d * (x + 1) <= N + c, so only numerators are kept.
    // Bottom band: edges 0 to 3 are 5w(i+1)+14 over 28, edges 4 to 6 are w(i+12)+10 over 21.
    // Seven-bar bands: w(i+1)+3 over 7.
    always_comb begin
        for (int i = 0; i < BOT_BARS - 1; i++) begin
            if (i < 4) n_bot_edge[i] = CW'(n_w) * CW'(5 * (i + 1)) + CW'(14);
            else       n_bot_edge[i] = CW'(n_w) * CW'(i + 12) + CW'(10);
        end
        for (int i = 0; i < SEV_BARS - 1; i++) begin
            n_sev_edge[i] = CW'(n_w) * CW'(i + 1) + CW'(3);
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_h        <= n_h;
        r_bot_edge <= n_bot_edge;
        r_sev_edge <= n_sev_edge;
    end

    assign o_w        = r_w;
    assign o_h        = r_h;
    assign o_bot_edge = r_bot_edge;
    assign o_sev_edge = r_sev_edge;

endmodule

// ===== hw/rtl/scb_pix.sv =====
// ----------------------------------------------------------------------------
// scb_pix: coordinate register, bar lookup and result register
// Two-stage pipeline; the result register is the output skid point.
// ----------------------------------------------------------------------------
module scb_pix #(
    parameter int WW = 13,
    parameter int HW = 13,
    parameter int CW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scb_in_if.sink        i_req,
    scb_out_if.source     o_res,
    input  logic [WW-1:0] i_w,
    input  logic [HW-1:0] i_h,
    input  logic [CW-1:0] i_bot_edge [scb_pkg::BOT_BARS-1],
    input  logic [CW-1:0] i_sev_edge [scb_pkg::SEV_BARS-1]
);
    import scb_pkg::*;

    logic             r_s1_valid;
    logic [COL_W-1:0] r_x;
    logic [ROW_W-1:0] r_y;
    logic             r_out_valid;
    t_color           r_color;
    logic             r_outside;

    logic          s2_load;
    logic          req_take;
    logic [CW-1:0] xp1;
    logic [CW-1:0] x7;
    logic [CW-1:0] x21;
    logic [CW-1:0] x28;
    logic [CW-1:0] y3;
    t_bar          bot_bar;
    t_bar          sev_bar;
    logic          outside;
    t_color        n_color;

    assign s2_load     = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_s1_valid || s2_load;
    assign req_take    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_take) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_x <= i_req.column;
            r_y <= i_req.row;
        end
    end

    // scaled column for the edge compares
    assign xp1 = CW'(r_x) + CW'(1);
    assign x7  = xp1 * CW'(7);
    assign x21 = xp1 * CW'(21);
    assign x28 = xp1 * CW'(28);
    assign y3  = (CW'(r_y) + CW'(1)) * CW'(3);

    assign outside = (CW'(r_x) >= CW'(i_w)) || (CW'(r_y) >= CW'(i_h));

    // first bar whose edge lies beyond the column
    always_comb begin
        bot_bar = t_bar'(BOT_BARS - 1);
        for (int i = BOT_BARS - 2; i >= 0; i--) begin
            if (i < 4) begin
                if (x28 <= i_bot_edge[i]) bot_bar = t_bar'(i);
            end else begin
                if (x21 <= i_bot_edge[i]) bot_bar = t_bar'(i);
            end
        end
        sev_bar = t_bar'(SEV_BARS - 1);
        for (int i = SEV_BARS - 2; i >= 0; i--) begin
            if (x7 <= i_sev_edge[i]) sev_bar = t_bar'(i);
        end
    end

    always_comb begin
        if (outside) begin
            n_color = '0;
        end else if (CW'(r_y) < CW'(i_h >> 2)) begin
            n_color = BOTTOM_BAND[bot_bar];
        end else if (y3 <= CW'(i_h)) begin
            n_color = MIDDLE_BAND[sev_bar];
        end else begin
            n_color = TOP_BAND[sev_bar];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_color   <= n_color;
            r_outside <= outside;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pixel_color   = r_color;
    assign o_res.outside_frame = r_outside;

endmodule

// ===== hw/rtl/smpte_color_bar_pixel.sv =====
// ----------------------------------------------------------------------------
// smpte_color_bar_pixel: colour bar test pattern, one pixel per request
// Maps a pixel coordinate to its 0xRRGGBB colour in a three-band bar pattern.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Payload                        Handshake
//  i_pix_in   in   column[11:0], row[11:0]        valid/ready
//  o_pix_out  out  pixel_color[23:0], outside     valid/ready
//  i_cfg_*    in   idx, data[12:0]                write enable, no stall
//
//  One request per clock sustained while the output is ready; an accepted
//  request passes the coordinate register, then the result register.
//  Reset clears only the valid flags and restores the 640x480 frame size.
//  A stalled result is held in the output register while one more request
//  can be taken into the coordinate register.
//  Edge thresholds follow a frame size write via the size, then edge registers.
//
module smpte_color_bar_pixel #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scb_in_if.sink             i_pix_in,
    scb_out_if.source          o_pix_out,
    input  logic               i_cfg_we,
    input  scb_pkg::t_cfg_idx  i_cfg_idx,
    input  scb_pkg::t_cfg_data i_cfg_data
);
    import scb_pkg::*;

    // width of clamped frame size
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    // compare width: edge numerators reach 20w+14, scaled column 28*4096
    localparam int CW0 = (WW + 5 > 17) ? WW + 5 : 17;
    localparam int CW  = (HW + 1 > CW0) ? HW + 1 : CW0;

    logic [WW-1:0] frame_w;
    logic [HW-1:0] frame_h;
    logic [CW-1:0] bot_edge [BOT_BARS-1];
    logic [CW-1:0] sev_edge [SEV_BARS-1];

    // frame size registers and precomputed edge numerators
    scb_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW),
        .CW         (CW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_w        (frame_w),
        .o_h        (frame_h),
        .o_bot_edge (bot_edge),
        .o_sev_edge (sev_edge)
    );

    // per-pixel pipeline: band select, bar search, colour lookup
    scb_pix #(
        .WW (WW),
        .HW (HW),
        .CW (CW)
    ) u_pix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_pix_in),
        .o_res      (o_pix_out),
        .i_w        (frame_w),
        .i_h        (frame_h),
        .i_bot_edge (bot_edge),
        .i_sev_edge (sev_edge)
    );

endmodule
